>>> rtl/rbt_pkg.sv
// Shared types, codes and the selector compare function for the breakpoint table.
`timescale 1ns / 1ps
`default_nettype none

package rbt_pkg;

  // Table geometry
  localparam int SLOTS_DEFAULT = 10;
  localparam int SLOT_W        = 4;

  // Operation codes
  typedef enum logic [1:0] {
    OP_SET       = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_CLEAR_ALL = 2'd2,
    OP_CHECK     = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_e;

  // Register selector codes
  localparam logic [4:0] SEL_A      = 5'd0;
  localparam logic [4:0] SEL_B      = 5'd1;
  localparam logic [4:0] SEL_C      = 5'd2;
  localparam logic [4:0] SEL_D      = 5'd3;
  localparam logic [4:0] SEL_E      = 5'd4;
  localparam logic [4:0] SEL_H      = 5'd5;
  localparam logic [4:0] SEL_L      = 5'd6;
  localparam logic [4:0] SEL_AF     = 5'd7;
  localparam logic [4:0] SEL_BC     = 5'd8;
  localparam logic [4:0] SEL_DE     = 5'd9;
  localparam logic [4:0] SEL_HL     = 5'd10;
  localparam logic [4:0] SEL_SP     = 5'd11;
  localparam logic [4:0] SEL_PC     = 5'd12;
  localparam logic [4:0] SEL_FLAG_Z = 5'd13;
  localparam logic [4:0] SEL_FLAG_N = 5'd14;
  localparam logic [4:0] SEL_FLAG_H = 5'd15;
  localparam logic [4:0] SEL_FLAG_C = 5'd16;
  localparam logic [4:0] SEL_LIMIT  = 5'd17;

  // Register snapshot as seen by every cell
  typedef struct packed {
    logic [15:0] af;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
  } snap_t;

  // Request held for the whole pass down the chain
  typedef struct packed {
    op_e         op;
    logic [4:0]  sel;
    logic [15:0] value;
    snap_t       snap;
  } req_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } tok_t;

  function automatic logic sel_known(logic [4:0] sel);
    return sel < SEL_LIMIT;
  endfunction

  // Does a stored selector/value pair match the snapshot
  function automatic logic sel_match(logic [4:0] sel, logic [15:0] value, snap_t s);
    logic [15:0] r;
    logic        is_flag;
    logic        fbit;
    logic        known;
    r       = '0;
    is_flag = 1'b0;
    fbit    = 1'b0;
    known   = 1'b1;
    case (sel)
      SEL_A:      r = {8'h00, s.af[15:8]};
      SEL_B:      r = {8'h00, s.bc[15:8]};
      SEL_C:      r = {8'h00, s.bc[7:0]};
      SEL_D:      r = {8'h00, s.de[15:8]};
      SEL_E:      r = {8'h00, s.de[7:0]};
      SEL_H:      r = {8'h00, s.hl[15:8]};
      SEL_L:      r = {8'h00, s.hl[7:0]};
      SEL_AF:     r = s.af;
      SEL_BC:     r = s.bc;
      SEL_DE:     r = s.de;
      SEL_HL:     r = s.hl;
      SEL_SP:     r = s.sp;
      SEL_PC:     r = s.pc;
      SEL_FLAG_Z: begin is_flag = 1'b1; fbit = s.af[7]; end
      SEL_FLAG_N: begin is_flag = 1'b1; fbit = s.af[6]; end
      SEL_FLAG_H: begin is_flag = 1'b1; fbit = s.af[5]; end
      SEL_FLAG_C: begin is_flag = 1'b1; fbit = s.af[4]; end
      default:    known = 1'b0;
    endcase
    if (is_flag) begin
      return fbit == (value != 16'd0);
    end
    return known && (r == value);
  endfunction

endpackage

`default_nettype wire

>>> rtl/rbt_cell.sv
// One breakpoint slot: holds its entry and acts on the token passing through it.
`timescale 1ns / 1ps
`default_nettype none

module rbt_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rbt_pkg::req_t req,
  input  wire rbt_pkg::tok_t tok_in,
  output rbt_pkg::tok_t      tok_out
);

  logic          valid;
  logic          valid_next;
  logic [4:0]    sel;
  logic [15:0]   value;
  logic          take;
  rbt_pkg::tok_t tok_next;

  // Slot action when the token arrives
  always_comb begin
    valid_next = valid;
    take       = 1'b0;
    tok_next   = tok_in;
    if (tok_in.active) begin
      unique case (req.op)
        rbt_pkg::OP_SET: begin
          if (!tok_in.found && !valid && rbt_pkg::sel_known(req.sel)) begin
            valid_next     = 1'b1;
            take           = 1'b1;
            tok_next.found = 1'b1;
          end
        end
        rbt_pkg::OP_CLEAR: begin
          if (!tok_in.found && valid && sel == req.sel) begin
            valid_next     = 1'b0;
            tok_next.found = 1'b1;
          end
        end
        rbt_pkg::OP_CLEAR_ALL: begin
          valid_next = 1'b0;
        end
        rbt_pkg::OP_CHECK: begin
          if (!tok_in.found && valid && rbt_pkg::sel_match(sel, value, req.snap)) begin
            valid_next     = 1'b0;
            tok_next.found = 1'b1;
            tok_next.slot  = rbt_pkg::SLOT_W'(IDX);
          end
        end
        default: ;
      endcase
    end
  end

  // Control state and token
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      valid   <= valid_next;
      tok_out <= tok_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) begin
      sel   <= req.sel;
      value <= req.value;
    end
  end

endmodule

`default_nettype wire

>>> rtl/register_breakpoint_table.sv
// Top level of the breakpoint table: request capture, cell chain and result staging.
//
//  channel | signals                                              | transfer when
//  --------+------------------------------------------------------+---------------------
//  in      | in_valid/in_ready, operation, reg_select,            | in_valid && in_ready
//          | match_value, reg_af..reg_pc                          |
//  out     | out_valid/out_ready, status, hit, hit_slot           | out_valid && out_ready
//
// One item at a time: a token walks the chain of SLOTS cells, one cell per cycle, so an
// item passes the launch register, each cell and the staging register before its result
// is valid; the next input is taken once the result moves into the output register.
// Reset empties every slot at once; no clearing pass.
// A stalled output holds its result; a second result waits in a staging register and
// the input stays not ready until it moves out.
`timescale 1ns / 1ps
`default_nettype none

module register_breakpoint_table #(
  parameter int SLOTS = rbt_pkg::SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [4:0]  reg_select,
  input  wire logic [15:0] match_value,
  input  wire logic [15:0] reg_af,
  input  wire logic [15:0] reg_bc,
  input  wire logic [15:0] reg_de,
  input  wire logic [15:0] reg_hl,
  input  wire logic [15:0] reg_sp,
  input  wire logic [15:0] reg_pc,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic             hit,
  output logic [3:0]       hit_slot
);

  rbt_pkg::req_t req;
  rbt_pkg::tok_t chain [SLOTS+1];
  logic          busy;
  logic          launch;
  logic          pend_valid;
  logic [1:0]    pend_status;
  logic          pend_hit;
  logic [3:0]    pend_slot;
  logic [1:0]    tail_status;
  logic          tail_hit;
  logic          accept;
  logic          move_out;
  rbt_pkg::tok_t tail;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign move_out = pend_valid && (!out_valid || out_ready);
  assign tail     = chain[SLOTS];

  // Token entering the first cell
  always_comb begin
    chain[0].active = launch;
    chain[0].found  = 1'b0;
    chain[0].slot   = '0;
  end

  // Cell chain
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rbt_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .req     (req),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Result from the token leaving the last cell
  always_comb begin
    tail_status = rbt_pkg::ST_OK;
    tail_hit    = 1'b0;
    unique case (req.op)
      rbt_pkg::OP_SET: begin
        if (!rbt_pkg::sel_known(req.sel)) tail_status = rbt_pkg::ST_UNKNOWN;
        else if (!tail.found)             tail_status = rbt_pkg::ST_FULL;
      end
      rbt_pkg::OP_CLEAR: begin
        if (!rbt_pkg::sel_known(req.sel)) tail_status = rbt_pkg::ST_UNKNOWN;
        else if (!tail.found)             tail_status = rbt_pkg::ST_NO_MATCH;
      end
      rbt_pkg::OP_CLEAR_ALL: ;
      rbt_pkg::OP_CHECK: tail_hit = tail.found;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      launch     <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      launch <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (move_out) begin
        busy <= 1'b0;
      end
      if (tail.active) begin
        pend_valid <= 1'b1;
      end else if (move_out) begin
        pend_valid <= 1'b0;
      end
      if (move_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req.op      <= rbt_pkg::op_e'(operation);
      req.sel     <= reg_select;
      req.value   <= match_value;
      req.snap.af <= reg_af;
      req.snap.bc <= reg_bc;
      req.snap.de <= reg_de;
      req.snap.hl <= reg_hl;
      req.snap.sp <= reg_sp;
      req.snap.pc <= reg_pc;
    end
    if (tail.active) begin
      pend_status <= tail_status;
      pend_hit    <= tail_hit;
      pend_slot   <= tail_hit ? tail.slot : 4'd0;
    end
    if (move_out) begin
      status   <= pend_status;
      hit      <= pend_hit;
      hit_slot <= pend_slot;
    end
  end

  // Checks
  a_tail_busy : assert property (@(posedge clk) disable iff (rst)
    tail.active |-> busy && !pend_valid)
    else $error("token left the chain with no item in flight");

  a_accept_launch : assert property (@(posedge clk) disable iff (rst)
    accept |=> launch && busy)
    else $error("accepted item did not enter the chain");

  a_pend_busy : assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy)
    else $error("staged result with no item in flight");

  a_hit_ok : assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == rbt_pkg::ST_OK)
    else $error("hit reported with error status");

  a_miss_slot : assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_slot == 4'd0)
    else $error("slot index reported without a hit");

endmodule

`default_nettype wire
